// File: src/gcbe_pkg.sv
// shared types, constants and command structs of the character buffer editor
`timescale 1ns / 1ps

package gcbe_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam int KIND_W   = 2;
  localparam int POS_W    = 10;
  localparam int CHAR_W   = 8;
  localparam int STAMP_W  = 48;
  localparam int STATUS_W = 3;
  localparam int EPOS_W   = 8;
  localparam int NLEN_W   = 9;

  localparam logic [CHAR_W-1:0] CHAR_LOW  = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] CHAR_HIGH = CHAR_W'(127);

  typedef enum logic [KIND_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BEYOND   = 3'd1,
    ST_NEGATIVE = 3'd2,
    ST_BADCHAR  = 3'd3,
    ST_FULL     = 3'd4
  } edit_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_PLACE,
    S_FETCH,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic shift;
    logic place;
    logic fetch;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    req_kind_t kind;
    logic      ok;
    logic      shift_done;
    logic      out_free;
  } dp_sts_t;

endpackage

// File: src/gcbe_if.sv
// valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps

interface gcbe_req_if;
  logic                                valid;
  logic                                ready;
  logic [gcbe_pkg::KIND_W-1:0]         req_type;
  logic signed [gcbe_pkg::POS_W-1:0]   position;
  logic [gcbe_pkg::CHAR_W-1:0]         new_char;
  logic [gcbe_pkg::STAMP_W-1:0]        now_seconds;

  modport source (output valid, req_type, position, new_char, now_seconds, input ready);
  modport sink (input valid, req_type, position, new_char, now_seconds, output ready);
endinterface

interface gcbe_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [gcbe_pkg::STATUS_W-1:0]   status;
  logic [gcbe_pkg::KIND_W-1:0]     edit_kind;
  logic [gcbe_pkg::EPOS_W-1:0]     edited_position;
  logic [gcbe_pkg::CHAR_W-1:0]     char_out;
  logic [gcbe_pkg::STAMP_W-1:0]    stamp_out;
  logic [gcbe_pkg::NLEN_W-1:0]     new_length;

  modport source (output valid, status, edit_kind, edited_position, char_out, stamp_out,
                  new_length, input ready);
  modport sink (input valid, status, edit_kind, edited_position, char_out, stamp_out,
                new_length, output ready);
endinterface

// File: src/gapless_char_buffer_editor_unit.sv
// top level of the gap-free character buffer editor
`timescale 1ns / 1ps

// Holds up to CAPACITY printable characters packed from slot 0 plus the current
// length, and serves one request transaction at a time: insert, remove or read
// at a zero-based position, each answered by one result transaction carrying
// status, kind, position, character, time stamp and the new length. A request
// with code 3 is dropped without a result. An insert or remove runs a shift
// walk over the characters at or behind the position, which moves one character
// per cycle through the single-write-port store, and every answered request
// also waits while the result register has not drained. Store slots at or
// above the length are never read, so the store needs no clearing pass after
// reset. A finished result waits in the output register while the next request
// is taken.
module gapless_char_buffer_editor_unit #(
  parameter int CAPACITY = gcbe_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  gcbe_req_if.sink   in_chan,
  gcbe_rsp_if.source out_chan
);

  gcbe_pkg::dp_cmd_t cmd;
  gcbe_pkg::dp_sts_t sts;

  gcbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gcbe_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_req_type         (in_chan.req_type),
    .in_position         (in_chan.position),
    .in_new_char         (in_chan.new_char),
    .in_now_seconds      (in_chan.now_seconds),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_status          (out_chan.status),
    .out_edit_kind       (out_chan.edit_kind),
    .out_edited_position (out_chan.edited_position),
    .out_char_out        (out_chan.char_out),
    .out_stamp_out       (out_chan.stamp_out),
    .out_new_length      (out_chan.new_length)
  );

endmodule

// File: src/gcbe_ctrl.sv
// controller state machine sequencing checks, shift walk, placement and result
`timescale 1ns / 1ps

module gcbe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gcbe_pkg::dp_sts_t sts,
  output gcbe_pkg::dp_cmd_t cmd
);

  gcbe_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gcbe_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gcbe_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = gcbe_pkg::S_CHECK;
        end
      end
      gcbe_pkg::S_CHECK: begin
        priority if (sts.kind == gcbe_pkg::REQ_NONE) begin
          state_nxt = gcbe_pkg::S_IDLE;
        end else if (!sts.ok) begin
          state_nxt = gcbe_pkg::S_RESP;
        end else if (sts.kind == gcbe_pkg::REQ_READ) begin
          state_nxt = gcbe_pkg::S_FETCH;
        end else begin
          state_nxt = gcbe_pkg::S_SHIFT;
        end
      end
      gcbe_pkg::S_SHIFT: begin
        if (sts.shift_done) begin
          state_nxt = (sts.kind == gcbe_pkg::REQ_INSERT) ? gcbe_pkg::S_PLACE
                                                         : gcbe_pkg::S_RESP;
        end
      end
      gcbe_pkg::S_PLACE: state_nxt = gcbe_pkg::S_RESP;
      gcbe_pkg::S_FETCH: state_nxt = gcbe_pkg::S_RESP;
      gcbe_pkg::S_RESP: begin
        if (sts.out_free) begin
          state_nxt = gcbe_pkg::S_IDLE;
        end
      end
      default: state_nxt = gcbe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      gcbe_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      gcbe_pkg::S_CHECK: cmd.setup  = 1'b1;
      gcbe_pkg::S_SHIFT: cmd.shift  = 1'b1;
      gcbe_pkg::S_PLACE: cmd.place  = 1'b1;
      gcbe_pkg::S_FETCH: cmd.fetch  = 1'b1;
      gcbe_pkg::S_RESP:  cmd.finish = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: src/gcbe_dp.sv
// datapath: request registers, checks, character store, shift walk and result register
`timescale 1ns / 1ps

module gcbe_dp #(
  parameter int CAPACITY = gcbe_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gcbe_pkg::dp_cmd_t                   cmd,
  output gcbe_pkg::dp_sts_t                   sts,
  input  logic [gcbe_pkg::KIND_W-1:0]         in_req_type,
  input  logic signed [gcbe_pkg::POS_W-1:0]   in_position,
  input  logic [gcbe_pkg::CHAR_W-1:0]         in_new_char,
  input  logic [gcbe_pkg::STAMP_W-1:0]        in_now_seconds,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gcbe_pkg::STATUS_W-1:0]       out_status,
  output logic [gcbe_pkg::KIND_W-1:0]         out_edit_kind,
  output logic [gcbe_pkg::EPOS_W-1:0]         out_edited_position,
  output logic [gcbe_pkg::CHAR_W-1:0]         out_char_out,
  output logic [gcbe_pkg::STAMP_W-1:0]        out_stamp_out,
  output logic [gcbe_pkg::NLEN_W-1:0]         out_new_length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > gcbe_pkg::POS_W) ? LW : gcbe_pkg::POS_W) + 1;
  localparam logic [LW-1:0] LEN_FULL = LW'(CAPACITY);

  gcbe_pkg::req_kind_t                kind_r;
  logic signed [gcbe_pkg::POS_W-1:0]  pos_r;
  logic [gcbe_pkg::CHAR_W-1:0]        ch_r;
  logic [gcbe_pkg::STAMP_W-1:0]       now_r;
  logic [LW-1:0]                      len_r;

  logic [gcbe_pkg::CHAR_W-1:0]        mem [CAPACITY];
  logic [gcbe_pkg::CHAR_W-1:0]        rd_data_r;
  logic [AW-1:0]                      rd_addr_r;
  logic [AW-1:0]                      wr_addr_r;
  logic [LW-1:0]                      rd_left_r;
  logic                               wr_pend_r;

  logic                               out_valid_r;
  logic [gcbe_pkg::STATUS_W-1:0]      status_r;
  logic [gcbe_pkg::KIND_W-1:0]        edit_kind_r;
  logic [gcbe_pkg::EPOS_W-1:0]        epos_r;
  logic [gcbe_pkg::CHAR_W-1:0]        char_r;
  logic [gcbe_pkg::STAMP_W-1:0]       stamp_r;
  logic [gcbe_pkg::NLEN_W-1:0]        nlen_r;

  logic signed [CW-1:0]               pos_x;
  logic signed [CW-1:0]               len_x;
  logic [LW-1:0]                      where_l;
  logic [AW-1:0]                      where_a;
  gcbe_pkg::edit_status_t             status;
  logic                               ok;
  logic [LW-1:0]                      len_new;
  logic [CW-1:0]                      len_new_x;
  logic                               mem_we;
  logic [AW-1:0]                      mem_waddr;
  logic [gcbe_pkg::CHAR_W-1:0]        mem_wdata;
  logic                               mem_re;

  assign pos_x   = {{(CW - gcbe_pkg::POS_W){pos_r[gcbe_pkg::POS_W-1]}}, pos_r};
  assign len_x   = $signed({{(CW - LW){1'b0}}, len_r});
  assign where_l = pos_x[LW-1:0];
  assign where_a = pos_x[AW-1:0];

  always_comb begin
    status = gcbe_pkg::ST_OK;
    if (kind_r == gcbe_pkg::REQ_INSERT) begin
      priority if (pos_x > len_x) begin
        status = gcbe_pkg::ST_BEYOND;
      end else if (pos_x < 0) begin
        status = gcbe_pkg::ST_NEGATIVE;
      end else if (ch_r < gcbe_pkg::CHAR_LOW || ch_r > gcbe_pkg::CHAR_HIGH) begin
        status = gcbe_pkg::ST_BADCHAR;
      end else if (len_r >= LEN_FULL) begin
        status = gcbe_pkg::ST_FULL;
      end else begin
        status = gcbe_pkg::ST_OK;
      end
    end else begin
      priority if (pos_x >= len_x) begin
        status = gcbe_pkg::ST_BEYOND;
      end else if (pos_x < 0) begin
        status = gcbe_pkg::ST_NEGATIVE;
      end else begin
        status = gcbe_pkg::ST_OK;
      end
    end
  end

  assign ok = (status == gcbe_pkg::ST_OK);

  always_comb begin
    len_new = len_r;
    if (ok && kind_r == gcbe_pkg::REQ_INSERT) begin
      len_new = len_r + LW'(1);
    end else if (ok && kind_r == gcbe_pkg::REQ_REMOVE) begin
      len_new = len_r - LW'(1);
    end
  end

  assign len_new_x = {{(CW - LW){1'b0}}, len_new};

  // store write port: shifted entry during the walk, new character at placement
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr_r;
    mem_wdata = rd_data_r;
    if (cmd.place) begin
      mem_we    = 1'b1;
      mem_waddr = where_a;
      mem_wdata = ch_r;
    end else if (cmd.shift && wr_pend_r) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = (cmd.shift && rd_left_r != '0) || cmd.fetch;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= gcbe_pkg::req_kind_t'(in_req_type);
      pos_r  <= in_position;
      ch_r   <= in_new_char;
      now_r  <= in_now_seconds;
    end
  end

  // shift walk: one read and one write per cycle, the write taking the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_left_r <= '0;
      wr_pend_r <= 1'b0;
    end else if (cmd.setup) begin
      wr_pend_r <= 1'b0;
      unique case (kind_r)
        gcbe_pkg::REQ_INSERT: begin
          rd_addr_r <= AW'(len_r - LW'(1));
          rd_left_r <= len_r - where_l;
        end
        gcbe_pkg::REQ_REMOVE: begin
          rd_addr_r <= AW'(where_l + LW'(1));
          rd_left_r <= len_r - where_l - LW'(1);
        end
        default: begin
          rd_addr_r <= where_a;
          rd_left_r <= '0;
        end
      endcase
    end else if (cmd.shift) begin
      if (rd_left_r != '0) begin
        rd_left_r <= rd_left_r - LW'(1);
        wr_pend_r <= 1'b1;
        if (kind_r == gcbe_pkg::REQ_INSERT) begin
          wr_addr_r <= rd_addr_r + AW'(1);
          rd_addr_r <= rd_addr_r - AW'(1);
        end else begin
          wr_addr_r <= rd_addr_r - AW'(1);
          rd_addr_r <= rd_addr_r + AW'(1);
        end
      end else begin
        wr_pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      len_r       <= len_new;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_r    <= status;
      edit_kind_r <= kind_r;
      nlen_r      <= len_new_x[gcbe_pkg::NLEN_W-1:0];
      epos_r      <= ok ? pos_x[gcbe_pkg::EPOS_W-1:0] : '0;
      char_r      <= '0;
      stamp_r     <= '0;
      if (ok) begin
        unique case (kind_r)
          gcbe_pkg::REQ_INSERT: begin
            char_r  <= ch_r;
            stamp_r <= now_r;
          end
          gcbe_pkg::REQ_REMOVE: stamp_r <= now_r;
          gcbe_pkg::REQ_READ:   char_r  <= rd_data_r;
          default: char_r <= '0;
        endcase
      end
    end
  end

  assign sts.kind       = kind_r;
  assign sts.ok         = ok;
  assign sts.shift_done = (rd_left_r == '0) && !wr_pend_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_edit_kind       = edit_kind_r;
  assign out_edited_position = epos_r;
  assign out_char_out        = char_r;
  assign out_stamp_out       = stamp_r;
  assign out_new_length      = nlen_r;

endmodule

// File: src/gcbe_checker.sv
// port-level assertions for the character buffer editor and their bind
`timescale 1ns / 1ps

module gcbe_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [gcbe_pkg::STATUS_W-1:0]     out_status,
  input logic [gcbe_pkg::KIND_W-1:0]       out_edit_kind,
  input logic [gcbe_pkg::EPOS_W-1:0]       out_edited_position,
  input logic [gcbe_pkg::CHAR_W-1:0]       out_char_out,
  input logic [gcbe_pkg::STAMP_W-1:0]      out_stamp_out,
  input logic [gcbe_pkg::NLEN_W-1:0]       out_new_length
);

  // no result transaction right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_new_length) && $stable(out_char_out))
    else $error("stalled result changed");

  // refused request reports no edit
  a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != gcbe_pkg::ST_OK |->
    out_edited_position == '0 && out_char_out == '0 && out_stamp_out == '0)
    else $error("refused request carries edit data");

  // reads carry no time stamp and dropped codes never show up
  a_read_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_edit_kind != gcbe_pkg::REQ_NONE &&
    (out_edit_kind != gcbe_pkg::REQ_READ || out_stamp_out == '0))
    else $error("bad kind or stamped read");

  // a remove result carries no character, whether it succeeds or not
  a_remove_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edit_kind == gcbe_pkg::REQ_REMOVE |-> out_char_out == '0)
    else $error("remove result carries a character");

endmodule

bind gapless_char_buffer_editor_unit gcbe_checker u_gcbe_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_status          (out_chan.status),
  .out_edit_kind       (out_chan.edit_kind),
  .out_edited_position (out_chan.edited_position),
  .out_char_out        (out_chan.char_out),
  .out_stamp_out       (out_chan.stamp_out),
  .out_new_length      (out_chan.new_length)
);

// File: dv/tb_top.sv
// self-checking testbench for the gap-free character buffer editor top level
`timescale 1ns / 1ps

module tb_top;

  localparam int CAP = gcbe_pkg::CAPACITY_DEF;

  typedef logic signed [gcbe_pkg::POS_W-1:0] pos_t;
  typedef logic [gcbe_pkg::CHAR_W-1:0]       char_t;
  typedef logic [gcbe_pkg::STAMP_W-1:0]      stamp_t;
  typedef logic [63:0]                       word_t;

  typedef struct packed {
    gcbe_pkg::edit_status_t          status;
    logic [gcbe_pkg::KIND_W-1:0]     kind;
    logic [gcbe_pkg::EPOS_W-1:0]     epos;
    logic [gcbe_pkg::CHAR_W-1:0]     chr;
    logic [gcbe_pkg::STAMP_W-1:0]    stamp;
    logic [gcbe_pkg::NLEN_W-1:0]     nlen;
  } edit_result_t;

  logic clk;
  logic rst_n;

  gcbe_req_if in_chan ();
  gcbe_rsp_if out_chan ();

  gapless_char_buffer_editor_unit #(
    .CAPACITY(CAP)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  char_t             text_model [CAP];
  int                text_len;
  edit_result_t      pending_q [$];

  int  errors;
  int  n_sent;
  int  n_checked;
  int  status_seen [8];
  int  rx_wait;
  int  hold_left;
  bit  tx_idle_on;
  bit  rx_idle_on;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #40ms;
    $display("gapless_char_buffer_editor_unit verification failed");
    $finish;
  end

  task automatic report_mismatch(string what, word_t got, word_t want);
    errors++;
    if (errors <= 40)
      $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic compare_field(string what, word_t got, word_t want);
    if (got !== want)
      report_mismatch(what, got, want);
  endtask

  // applies one request to the local copy of the buffer
  function automatic logic apply_edit(input gcbe_pkg::req_kind_t k, input pos_t p,
                                      input char_t c, input stamp_t t,
                                      output edit_result_t r);
    int ps;
    int idx;
    ps = p;
    r = '0;
    r.kind = k;
    if (k == gcbe_pkg::REQ_NONE)
      return 1'b0;
    r.status = gcbe_pkg::ST_OK;
    if (k == gcbe_pkg::REQ_INSERT) begin
      if (ps > text_len)
        r.status = gcbe_pkg::ST_BEYOND;
      else if (ps < 0)
        r.status = gcbe_pkg::ST_NEGATIVE;
      else if (c < gcbe_pkg::CHAR_LOW || c > gcbe_pkg::CHAR_HIGH)
        r.status = gcbe_pkg::ST_BADCHAR;
      else if (text_len >= CAP)
        r.status = gcbe_pkg::ST_FULL;
      else begin
        for (idx = text_len; idx > ps; idx--)
          text_model[idx] = text_model[idx-1];
        text_model[ps] = c;
        text_len++;
        r.epos = ps[gcbe_pkg::EPOS_W-1:0];
        r.chr = c;
        r.stamp = t;
      end
    end else begin
      if (ps >= text_len)
        r.status = gcbe_pkg::ST_BEYOND;
      else if (ps < 0)
        r.status = gcbe_pkg::ST_NEGATIVE;
      else begin
        r.epos = ps[gcbe_pkg::EPOS_W-1:0];
        if (k == gcbe_pkg::REQ_REMOVE) begin
          for (idx = ps; idx + 1 < text_len; idx++)
            text_model[idx] = text_model[idx+1];
          text_model[text_len-1] = '0;
          text_len--;
          r.stamp = t;
        end else begin
          r.chr = text_model[ps];
        end
      end
    end
    r.nlen = text_len[gcbe_pkg::NLEN_W-1:0];
    return 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    edit_result_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      rx_wait = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing pending, status", word_t'(out_chan.status), '0);
      end else begin
        want = pending_q.pop_front();
        compare_field("status", word_t'(out_chan.status), word_t'(want.status));
        compare_field("edit_kind", word_t'(out_chan.edit_kind), word_t'(want.kind));
        compare_field("edited_position", word_t'(out_chan.edited_position),
                      word_t'(want.epos));
        compare_field("char_out", word_t'(out_chan.char_out), word_t'(want.chr));
        compare_field("stamp_out", word_t'(out_chan.stamp_out), word_t'(want.stamp));
        compare_field("new_length", word_t'(out_chan.new_length), word_t'(want.nlen));
        status_seen[want.status]++;
        n_checked++;
      end
    end
  end

  // result receiver with random stalls and long hold-offs
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (rx_wait > 0) begin
        out_chan.ready <= 1'b0;
        rx_wait--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic send_req(gcbe_pkg::req_kind_t k, pos_t p, char_t c, stamp_t t);
    int gap;
    edit_result_t r;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.req_type <= k;
    in_chan.position <= p;
    in_chan.new_char <= c;
    in_chan.now_seconds <= t;
    @(posedge clk);
    while (in_chan.ready !== 1'b1)
      @(posedge clk);
    n_sent++;
    if (apply_edit(k, p, c, t, r))
      pending_q.push_back(r);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_q.size() != 0) begin
      report_mismatch("results never arrived, count", word_t'(pending_q.size()), '0);
      pending_q.delete();
    end
    repeat (20) @(posedge clk);
  endtask

  function automatic stamp_t rand_stamp();
    return stamp_t'({$urandom, $urandom});
  endfunction

  task automatic test_directed();
    send_req(gcbe_pkg::REQ_READ, '0, 8'd0, rand_stamp());
    send_req(gcbe_pkg::REQ_REMOVE, '0, 8'd0, rand_stamp());
    send_req(gcbe_pkg::REQ_INSERT, pos_t'(1), 8'd65, rand_stamp());
    send_req(gcbe_pkg::REQ_INSERT, pos_t'(-1), 8'd65, rand_stamp());
    send_req(gcbe_pkg::REQ_INSERT, pos_t'(-512), 8'd65, rand_stamp());
    send_req(gcbe_pkg::REQ_INSERT, pos_t'(511), 8'd65, rand_stamp());
    send_req(gcbe_pkg::REQ_INSERT, '0, 8'd31, rand_stamp());
    send_req(gcbe_pkg::REQ_INSERT, '0, 8'd128, rand_stamp());
    send_req(gcbe_pkg::REQ_INSERT, '0, 8'd0, rand_stamp());
    send_req(gcbe_pkg::REQ_INSERT, '0, 8'd255, rand_stamp());
    send_req(gcbe_pkg::REQ_INSERT, '0, gcbe_pkg::CHAR_LOW, {gcbe_pkg::STAMP_W{1'b1}});
    send_req(gcbe_pkg::REQ_INSERT, '0, gcbe_pkg::CHAR_HIGH, '0);
    send_req(gcbe_pkg::REQ_INSERT, pos_t'(1), 8'd77, rand_stamp());
    send_req(gcbe_pkg::REQ_INSERT, pos_t'(3), 8'd90, rand_stamp());
    send_req(gcbe_pkg::REQ_NONE, '0, 8'd66, rand_stamp());
    send_req(gcbe_pkg::REQ_READ, '0, 8'd0, rand_stamp());
    send_req(gcbe_pkg::REQ_READ, pos_t'(3), 8'd0, rand_stamp());
    send_req(gcbe_pkg::REQ_READ, pos_t'(-1), 8'd0, rand_stamp());
    send_req(gcbe_pkg::REQ_READ, pos_t'(4), 8'd0, rand_stamp());
    send_req(gcbe_pkg::REQ_REMOVE, pos_t'(1), 8'd0, rand_stamp());
    send_req(gcbe_pkg::REQ_REMOVE, pos_t'(2), 8'd0, rand_stamp());
    send_req(gcbe_pkg::REQ_REMOVE, pos_t'(-512), 8'd0, rand_stamp());
    send_req(gcbe_pkg::REQ_REMOVE, '0, 8'd0, {gcbe_pkg::STAMP_W{1'b1}});
    send_req(gcbe_pkg::REQ_REMOVE, '0, 8'd0, rand_stamp());
    wait_idle();
  endtask

  task automatic test_fill_and_empty();
    while (text_len < CAP)
      send_req(gcbe_pkg::REQ_INSERT, pos_t'($urandom_range(0, text_len)),
               char_t'($urandom_range(32, 127)), rand_stamp());
    send_req(gcbe_pkg::REQ_INSERT, '0, 8'd65, rand_stamp());
    send_req(gcbe_pkg::REQ_INSERT, pos_t'(CAP), 8'd65, rand_stamp());
    send_req(gcbe_pkg::REQ_INSERT, pos_t'(CAP + 1), 8'd65, rand_stamp());
    send_req(gcbe_pkg::REQ_READ, pos_t'(CAP - 1), 8'd0, rand_stamp());
    send_req(gcbe_pkg::REQ_READ, pos_t'(CAP), 8'd0, rand_stamp());
    send_req(gcbe_pkg::REQ_REMOVE, pos_t'(CAP - 1), 8'd0, rand_stamp());
    while (text_len > 0)
      send_req(gcbe_pkg::REQ_REMOVE, pos_t'($urandom_range(0, text_len - 1)), 8'd0,
               rand_stamp());
    send_req(gcbe_pkg::REQ_READ, '0, 8'd0, rand_stamp());
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    hold_left = 300;
    for (int i = 0; i < 16; i++) begin
      if (i % 3 == 2 && text_len > 0)
        send_req(gcbe_pkg::REQ_READ, pos_t'($urandom_range(0, text_len - 1)), 8'd0,
                 rand_stamp());
      else
        send_req(gcbe_pkg::REQ_INSERT, pos_t'(text_len), char_t'($urandom_range(32, 127)),
                 rand_stamp());
    end
    wait_idle();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random(int n_items);
    int target;
    int sel;
    gcbe_pkg::req_kind_t k;
    pos_t p;
    char_t c;
    target = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 150 == 0) begin
        sel = $urandom_range(0, 9);
        target = (sel < 6) ? $urandom_range(0, 32) : (sel < 9) ? $urandom_range(0, CAP) : CAP;
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      sel = $urandom_range(0, 99);
      c = '0;
      if (sel < 8) begin
        // noise: any code, any position, any byte
        k = gcbe_pkg::req_kind_t'($urandom_range(0, 3));
        p = pos_t'($urandom);
        c = char_t'($urandom);
      end else if (sel < 25) begin
        k = gcbe_pkg::REQ_READ;
        p = (text_len == 0) ? '0 : pos_t'($urandom_range(0, text_len - 1));
      end else if ((text_len < target) ? ($urandom_range(0, 99) < 85)
                                       : ($urandom_range(0, 99) < 15)) begin
        k = gcbe_pkg::REQ_INSERT;
        p = pos_t'($urandom_range(0, text_len));
        c = char_t'($urandom_range(32, 127));
      end else begin
        k = gcbe_pkg::REQ_REMOVE;
        p = (text_len == 0) ? '0 : pos_t'($urandom_range(0, text_len - 1));
      end
      send_req(k, p, c, rand_stamp());
    end
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.req_type = '0;
    in_chan.position = '0;
    in_chan.new_char = '0;
    in_chan.now_seconds = '0;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    rx_wait = 0;
    hold_left = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    text_len = 0;
    foreach (text_model[i]) text_model[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_empty();
    test_backpressure();
    test_random(1450);

    repeat (300) @(posedge clk);
    $display("covered %0d requests and %0d checked results, including a full buffer",
             n_sent, n_checked);
    $display("statuses seen: ok %0d, beyond %0d, negative %0d, bad char %0d, full %0d",
             status_seen[gcbe_pkg::ST_OK], status_seen[gcbe_pkg::ST_BEYOND],
             status_seen[gcbe_pkg::ST_NEGATIVE], status_seen[gcbe_pkg::ST_BADCHAR],
             status_seen[gcbe_pkg::ST_FULL]);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("gapless_char_buffer_editor_unit verification clean");
    end else begin
      $display("gapless_char_buffer_editor_unit verification failed");
    end
    $finish;
  end

endmodule
